### rtl/assert_macros.svh
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/cgsp_pkg.sv
// Package: shared types and constants of the cooldown-gated shutter pulser.
`timescale 1ns / 1ps
package cgsp_pkg;

  // Request bits and cooldown registers that exist on the interface
  localparam int unsigned SRC_SLOTS = 4;
  localparam int unsigned SRC_IDX_W = 2;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_LENGTH = 3'd0,
    REG_ACTIVE_SRCS  = 3'd1,
    REG_COOLDOWN0    = 3'd2,
    REG_COOLDOWN1    = 3'd3,
    REG_COOLDOWN2    = 3'd4,
    REG_COOLDOWN3    = 3'd5
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [TIME_W-1:0] PULSE_LENGTH_RST = 32'd100;
  localparam logic [CNT_W-1:0]  ACTIVE_SRCS_RST  = 3'd4;

  // Outcome of the priority pick
  typedef struct packed {
    logic                 fire;
    logic [SRC_IDX_W-1:0] src;
  } pick_t;

endpackage

### rtl/cgsp_pick.sv
// Per-source cooldown check and lowest-index priority pick.
`timescale 1ns / 1ps
module cgsp_pick #(
  parameter int unsigned NUM_SLOTS = 4
) (
  input  logic [cgsp_pkg::TIME_W-1:0]    now_i,
  input  logic [cgsp_pkg::SRC_SLOTS-1:0] req_i,
  input  logic [cgsp_pkg::CNT_W-1:0]     count_i,
  input  logic [NUM_SLOTS-1:0]           has_fired_i,
  input  logic [cgsp_pkg::TIME_W-1:0]    last_fire_i [NUM_SLOTS],
  input  logic [cgsp_pkg::TIME_W-1:0]    cooldown_i  [NUM_SLOTS],
  output cgsp_pkg::pick_t                pick_o
);

  logic [NUM_SLOTS-1:0]          eligible;
  logic [cgsp_pkg::TIME_W-1:0]   elapsed [NUM_SLOTS];

  // Parallel cooldown checks, wrapping subtraction
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      elapsed[i]  = now_i - last_fire_i[i];
      eligible[i] = req_i[i] && (cgsp_pkg::CNT_W'(i) < count_i) &&
                    (!has_fired_i[i] || (elapsed[i] >= cooldown_i[i]));
    end
  end

  // Lowest-numbered eligible source wins
  always_comb begin
    pick_o = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (eligible[i]) begin
        pick_o.fire = 1'b1;
        pick_o.src  = cgsp_pkg::SRC_IDX_W'(i);
      end
    end
  end

endmodule

### rtl/cooldown_gated_shutter_pulser_core.sv
// Top level: cooldown-gated shutter pulser with registered result beat.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one beat per update: a
//   wrapping millisecond timestamp, the focus level and a four-bit mask of
//   fire requests. Output channel (out_valid_o/out_ready_i) returns exactly
//   one beat per input beat: focus and shutter levels, a fired flag and the
//   index of the source that started the pulse.
//   The result of a beat accepted at one edge is valid after that edge.
//   Throughput is one beat per cycle while the receiver takes each result;
//   cooldown checks, priority pick and pulse timer all settle in the single
//   stage between the input port and the result register.
//   When the receiver stalls, the result register holds its beat and
//   in_ready_o drops until the beat is taken; a new beat is accepted in the
//   same cycle the held one leaves.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i);
//   the user writes it only while the block is idle, which the block does
//   not enforce; unknown indexes are ignored. Reset clears pulse and source
//   state, loads register defaults (pulse length 100, four active sources,
//   zero cooldowns) and empties the result register.
module cooldown_gated_shutter_pulser_core #(
  parameter int unsigned NUM_SOURCES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] now_ms_i,
  input  logic        focus_held_i,
  input  logic [3:0]  fire_requests_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        focus_drive_o,
  output logic        shutter_drive_o,
  output logic        fired_o,
  output logic [1:0]  fired_source_o
);

  localparam int unsigned NumSlots =
    (NUM_SOURCES < cgsp_pkg::SRC_SLOTS) ? NUM_SOURCES : cgsp_pkg::SRC_SLOTS;

  // Configuration registers
  logic [cgsp_pkg::TIME_W-1:0] pulse_len_q;
  logic [cgsp_pkg::CNT_W-1:0]  active_q;
  logic [cgsp_pkg::TIME_W-1:0] cooldown_q [NumSlots];

  // Pulse and source state
  logic                        pulse_active_q, pulse_active_d;
  logic [cgsp_pkg::TIME_W-1:0] pulse_start_q, pulse_start_d;
  logic [cgsp_pkg::TIME_W-1:0] last_fire_q [NumSlots];
  logic [cgsp_pkg::TIME_W-1:0] last_fire_d [NumSlots];
  logic [NumSlots-1:0]         has_fired_q, has_fired_d;

  // Result register
  logic                              out_valid_q, out_valid_d;
  logic                              focus_q, shutter_q, fired_q;
  logic [cgsp_pkg::SRC_IDX_W-1:0]    src_q;

  logic                        accept;
  logic [cgsp_pkg::CNT_W-1:0]  count;
  logic [cgsp_pkg::TIME_W-1:0] pulse_age;
  cgsp_pkg::pick_t             pick;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Active count capped at the number of slots
  assign count = (active_q > cgsp_pkg::CNT_W'(NumSlots)) ?
                 cgsp_pkg::CNT_W'(NumSlots) : active_q;

  cgsp_pick #(
    .NUM_SLOTS (NumSlots)
  ) u_pick (
    .now_i       (now_ms_i),
    .req_i       (fire_requests_i),
    .count_i     (count),
    .has_fired_i (has_fired_q),
    .last_fire_i (last_fire_q),
    .cooldown_i  (cooldown_q),
    .pick_o      (pick)
  );

  assign pulse_age = now_ms_i - pulse_start_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_len_q <= cgsp_pkg::PULSE_LENGTH_RST;
      active_q    <= cgsp_pkg::ACTIVE_SRCS_RST;
      for (int i = 0; i < NumSlots; i++) cooldown_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cgsp_pkg::cfg_reg_e'(cfg_idx_i))
        cgsp_pkg::REG_PULSE_LENGTH: pulse_len_q <= cfg_wdata_i;
        cgsp_pkg::REG_ACTIVE_SRCS:  active_q    <= cfg_wdata_i[cgsp_pkg::CNT_W-1:0];
        cgsp_pkg::REG_COOLDOWN0,
        cgsp_pkg::REG_COOLDOWN1,
        cgsp_pkg::REG_COOLDOWN2,
        cgsp_pkg::REG_COOLDOWN3: begin
          for (int i = 0; i < NumSlots; i++) begin
            if (cfg_idx_i == cgsp_pkg::CFG_IDX_W'(int'(cgsp_pkg::REG_COOLDOWN0) + i)) begin
              cooldown_q[i] <= cfg_wdata_i;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Next state: fire when idle, otherwise run the pulse timer
  always_comb begin
    pulse_active_d = pulse_active_q;
    pulse_start_d  = pulse_start_q;
    last_fire_d    = last_fire_q;
    has_fired_d    = has_fired_q;
    if (accept) begin
      if (!pulse_active_q) begin
        if (pick.fire) begin
          pulse_active_d = 1'b1;
          pulse_start_d  = now_ms_i;
          for (int i = 0; i < NumSlots; i++) begin
            if (pick.src == cgsp_pkg::SRC_IDX_W'(i)) begin
              last_fire_d[i] = now_ms_i;
              has_fired_d[i] = 1'b1;
            end
          end
        end
      end else if (pulse_age >= pulse_len_q) begin
        pulse_active_d = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_active_q <= 1'b0;
      pulse_start_q  <= '0;
      has_fired_q    <= '0;
      for (int i = 0; i < NumSlots; i++) last_fire_q[i] <= '0;
    end else begin
      pulse_active_q <= pulse_active_d;
      pulse_start_q  <= pulse_start_d;
      has_fired_q    <= has_fired_d;
      last_fire_q    <= last_fire_d;
    end
  end

  // Result beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      focus_q   <= focus_held_i;
      shutter_q <= pulse_active_d;
      fired_q   <= !pulse_active_q && pick.fire;
      src_q     <= (!pulse_active_q && pick.fire) ? pick.src : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign focus_drive_o   = focus_q;
  assign shutter_drive_o = shutter_q;
  assign fired_o         = fired_q;
  assign fired_source_o  = src_q;

endmodule

### rtl/cgsp_checker.sv
// Checker: port-level assertions on the shutter pulser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cgsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        shutter_drive_o,
  input logic        fired_o,
  input logic [1:0]  fired_source_o
);

  // A beat that starts a pulse shows the shutter high
  `ASSERT_IMPLY(a_fire_opens, clk_i, rst_ni, out_valid_o && fired_o, shutter_drive_o)

  // No fire, no source index
  `ASSERT_IMPLY(a_src_zero, clk_i, rst_ni, out_valid_o && !fired_o, fired_source_o == 2'd0)

  // Every accepted input beat yields a result beat on the next cycle
  `ASSERT_NEXT(a_one_cycle, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)

  // Stalled result holds
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
               out_valid_o && $stable(fired_o) && $stable(shutter_drive_o))

endmodule

bind cooldown_gated_shutter_pulser_core cgsp_checker u_cgsp_checker (.*);

### tb/tb_top.sv
// Testbench for the cooldown-gated shutter pulser: directed table plus random traffic.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned NUM_SRC = 4;
  localparam logic [31:0] MS_MAX  = 32'hFFFF_FFFF;
  // Indexes past the last register, writes there must be ignored
  localparam logic [cgsp_pkg::CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [cgsp_pkg::CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
  localparam int HOLD_OFF_CYCLES  = 60;
  localparam int RANDOM_PHASES    = 9;
  localparam int PHASE_UPDATES    = 60;

  // One result beat as seen on the output channel
  typedef struct packed {
    logic                           focus;
    logic                           shutter;
    logic                           fired;
    logic [cgsp_pkg::SRC_IDX_W-1:0] src;
  } shutter_beat_t;

  typedef enum logic {ROW_UPDATE, ROW_WRITE} row_kind_e;

  // Directed row: an update beat, or a register write between beats
  typedef struct packed {
    row_kind_e                      kind;
    logic [cgsp_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                    value;  // timestamp, or write data on write rows
    logic                           focus;
    logic [3:0]                     req;
    logic                           known;  // expected beat typed into the row
    shutter_beat_t                  want;
  } stim_row_t;

  // Typed expectation travelling with each offered update
  typedef struct packed {
    logic          known;
    shutter_beat_t want;
  } beat_note_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  cfg_idx_i       = '0;
  logic [31:0] cfg_wdata_i     = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [31:0] now_ms_i        = '0;
  logic        focus_held_i    = 1'b0;
  logic [3:0]  fire_requests_i = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        focus_drive_o;
  logic        shutter_drive_o;
  logic        fired_o;
  logic [1:0]  fired_source_o;

  cooldown_gated_shutter_pulser_core #(
    .NUM_SOURCES (NUM_SRC)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .now_ms_i        (now_ms_i),
    .focus_held_i    (focus_held_i),
    .fire_requests_i (fire_requests_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .focus_drive_o   (focus_drive_o),
    .shutter_drive_o (shutter_drive_o),
    .fired_o         (fired_o),
    .fired_source_o  (fired_source_o)
  );

  // Register mirror
  logic [31:0]                pulse_len_ms;
  logic [cgsp_pkg::CNT_W-1:0] active_cnt;
  logic [31:0]                cooldown_ms [cgsp_pkg::SRC_SLOTS];

  // Pulser state mirror
  logic             pulse_on;
  logic [31:0]      pulse_t0;
  logic [31:0]      last_fire_ms [cgsp_pkg::SRC_SLOTS];
  logic             src_has_fired [cgsp_pkg::SRC_SLOTS];

  shutter_beat_t awaited_beats [$];
  beat_note_t    typed_notes [$];
  stim_row_t     directed_rows [$];

  int  fault_count   = 0;
  int  updates_sent  = 0;
  int  pulses_seen   = 0;
  int  settings_used = 0;
  bit  sender_idle   = 1'b1;
  bit  receiver_idle = 1'b1;
  bit  hold_off_req  = 1'b0;

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #400000;
    $display("FAIL cooldown_gated_shutter_pulser_core");
    $finish;
  end

  // Shutter prediction for one update; advances the state mirror
  function automatic shutter_beat_t advance_shutter(input logic [31:0] t, input logic f,
                                                    input logic [3:0] req);
    shutter_beat_t res;
    int unsigned   n;
    logic [31:0]   since;
    res       = '0;
    res.focus = f;
    n = 32'(active_cnt);
    if (n > NUM_SRC) n = NUM_SRC;
    if (n > cgsp_pkg::SRC_SLOTS) n = cgsp_pkg::SRC_SLOTS;
    if (!pulse_on) begin
      // lowest eligible requester wins, the rest are dropped
      for (int i = 0; i < int'(n); i++) begin
        since = t - last_fire_ms[i];
        if (!res.fired && req[i] && (!src_has_fired[i] || since >= cooldown_ms[i])) begin
          res.fired        = 1'b1;
          res.src          = cgsp_pkg::SRC_IDX_W'(i);
          pulse_on         = 1'b1;
          pulse_t0         = t;
          last_fire_ms[i]  = t;
          src_has_fired[i] = 1'b1;
        end
      end
    end else begin
      since = t - pulse_t0;
      if (since >= pulse_len_ms) pulse_on = 1'b0;
    end
    res.shutter = pulse_on;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  // Input and output monitor; inputs are predicted before outputs are popped
  always @(posedge clk_i) begin
    shutter_beat_t guess;
    beat_note_t    note;
    shutter_beat_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        guess = advance_shutter(now_ms_i, focus_held_i, fire_requests_i);
        note  = (typed_notes.size() != 0) ? typed_notes.pop_front() : '0;
        awaited_beats.push_back(note.known ? note.want : guess);
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_beats.size() == 0) begin
          $error("result beat with no update outstanding");
          fault_count++;
        end else begin
          want = awaited_beats.pop_front();
          check_field("focus_drive", 32'(want.focus), 32'(focus_drive_o));
          check_field("shutter_drive", 32'(want.shutter), 32'(shutter_drive_o));
          check_field("fired", 32'(want.fired), 32'(fired_o));
          check_field("fired_source", 32'(want.src), 32'(fired_source_o));
          if (fired_o === 1'b1) pulses_seen++;
        end
      end
    end
  end

  // Receiver: random stall per beat, one long hold-off on request
  initial begin : receiver
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        stall        = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        stall = receiver_idle ? $urandom_range(0, 15) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Offer one update beat and hold it until taken
  task automatic send_update(input logic [31:0] t, input logic f, input logic [3:0] req,
                             input logic known, input shutter_beat_t want);
    int gap;
    gap = sender_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    typed_notes.push_back('{known, want});
    in_valid_i      <= 1'b1;
    now_ms_i        <= t;
    focus_held_i    <= f;
    fire_requests_i <= req;
    updates_sent++;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // Drop valid and wait until every result beat has come back
  task automatic drain_updates();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cgsp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      cgsp_pkg::REG_PULSE_LENGTH: pulse_len_ms   = data;
      cgsp_pkg::REG_ACTIVE_SRCS:  active_cnt     = data[cgsp_pkg::CNT_W-1:0];
      cgsp_pkg::REG_COOLDOWN0:    cooldown_ms[0] = data;
      cgsp_pkg::REG_COOLDOWN1:    cooldown_ms[1] = data;
      cgsp_pkg::REG_COOLDOWN2:    cooldown_ms[2] = data;
      cgsp_pkg::REG_COOLDOWN3:    cooldown_ms[3] = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Interval value: mostly short, sometimes zero, max or anything
  function automatic logic [31:0] pick_span();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return MS_MAX;
    if (roll == 2) return $urandom;
    return $urandom_range(0, 30);
  endfunction

  initial begin : stimulus
    logic [31:0] clock;
    logic [31:0] len;
    logic [31:0] cd;
    logic [31:0] act;
    int          roll;
    int          guard;

    pulse_len_ms = cgsp_pkg::PULSE_LENGTH_RST;
    active_cnt   = cgsp_pkg::ACTIVE_SRCS_RST;
    pulse_on     = 1'b0;
    pulse_t0     = '0;
    for (int i = 0; i < cgsp_pkg::SRC_SLOTS; i++) begin
      cooldown_ms[i]   = '0;
      last_fire_ms[i]  = '0;
      src_has_fired[i] = 1'b0;
    end

    // Directed rows: reset defaults, priority, pulse end vs request, zero length,
    // zero and oversized active counts, spare indexes, wrapping time
    directed_rows = '{
      '{ROW_UPDATE, '0, 32'd0,    1'b1, 4'b0000, 1'b1, '{1'b1, 1'b0, 1'b0, 2'd0}},
      '{ROW_UPDATE, '0, 32'd0,    1'b0, 4'b1010, 1'b1, '{1'b0, 1'b1, 1'b1, 2'd1}},
      '{ROW_UPDATE, '0, 32'd50,   1'b0, 4'b0001, 1'b1, '{1'b0, 1'b1, 1'b0, 2'd0}},
      '{ROW_UPDATE, '0, 32'd100,  1'b0, 4'b0001, 1'b1, '{1'b0, 1'b0, 1'b0, 2'd0}},
      '{ROW_UPDATE, '0, 32'd101,  1'b1, 4'b0001, 1'b1, '{1'b1, 1'b1, 1'b1, 2'd0}},
      '{ROW_WRITE, cgsp_pkg::REG_COOLDOWN0, 32'd1000, 1'b0, 4'b0000, 1'b0, '0},
      '{ROW_WRITE, cgsp_pkg::REG_PULSE_LENGTH, 32'd0, 1'b0, 4'b0000, 1'b0, '0},
      '{ROW_UPDATE, '0, 32'd200,  1'b0, 4'b0001, 1'b1, '{1'b0, 1'b0, 1'b0, 2'd0}},
      '{ROW_UPDATE, '0, 32'd201,  1'b0, 4'b0001, 1'b1, '{1'b0, 1'b0, 1'b0, 2'd0}},
      '{ROW_UPDATE, '0, 32'd1101, 1'b0, 4'b0001, 1'b1, '{1'b0, 1'b1, 1'b1, 2'd0}},
      '{ROW_UPDATE, '0, 32'd1101, 1'b1, 4'b0000, 1'b1, '{1'b1, 1'b0, 1'b0, 2'd0}},
      '{ROW_WRITE, cgsp_pkg::REG_ACTIVE_SRCS, 32'd0,  1'b0, 4'b0000, 1'b0, '0},
      '{ROW_UPDATE, '0, 32'd1200, 1'b0, 4'b1111, 1'b1, '{1'b0, 1'b0, 1'b0, 2'd0}},
      '{ROW_WRITE, cgsp_pkg::REG_ACTIVE_SRCS, 32'd7,  1'b0, 4'b0000, 1'b0, '0},
      '{ROW_UPDATE, '0, 32'd1300, 1'b0, 4'b1000, 1'b1, '{1'b0, 1'b1, 1'b1, 2'd3}},
      '{ROW_UPDATE, '0, 32'd1300, 1'b0, 4'b0000, 1'b1, '{1'b0, 1'b0, 1'b0, 2'd0}},
      '{ROW_WRITE, cgsp_pkg::REG_ACTIVE_SRCS, 32'd2,  1'b0, 4'b0000, 1'b0, '0},
      '{ROW_UPDATE, '0, 32'd1400, 1'b0, 4'b1100, 1'b1, '{1'b0, 1'b0, 1'b0, 2'd0}},
      '{ROW_UPDATE, '0, 32'd1400, 1'b1, 4'b1110, 1'b1, '{1'b1, 1'b1, 1'b1, 2'd1}},
      '{ROW_WRITE, REG_SPARE6, 32'd5,        1'b0, 4'b0000, 1'b0, '0},
      '{ROW_WRITE, REG_SPARE7, MS_MAX,       1'b0, 4'b0000, 1'b0, '0},
      '{ROW_WRITE, cgsp_pkg::REG_PULSE_LENGTH, MS_MAX, 1'b0, 4'b0000, 1'b0, '0},
      '{ROW_UPDATE, '0, 32'd1400, 1'b0, 4'b0000, 1'b1, '{1'b0, 1'b1, 1'b0, 2'd0}},
      '{ROW_UPDATE, '0, MS_MAX,   1'b1, 4'b1111, 1'b1, '{1'b1, 1'b1, 1'b0, 2'd0}},
      '{ROW_UPDATE, '0, 32'd1399, 1'b0, 4'b0000, 1'b1, '{1'b0, 1'b0, 1'b0, 2'd0}},
      '{ROW_WRITE, cgsp_pkg::REG_COOLDOWN2, MS_MAX,       1'b0, 4'b0000, 1'b0, '0},
      '{ROW_WRITE, cgsp_pkg::REG_COOLDOWN1, MS_MAX,       1'b0, 4'b0000, 1'b0, '0},
      '{ROW_WRITE, cgsp_pkg::REG_ACTIVE_SRCS, 32'hFFFF_FFFC, 1'b0, 4'b0000, 1'b0, '0},
      '{ROW_WRITE, cgsp_pkg::REG_PULSE_LENGTH, 32'd5,     1'b0, 4'b0000, 1'b0, '0},
      '{ROW_UPDATE, '0, 32'd0,    1'b0, 4'b0100, 1'b1, '{1'b0, 1'b1, 1'b1, 2'd2}},
      '{ROW_UPDATE, '0, 32'd3,    1'b0, 4'b0100, 1'b1, '{1'b0, 1'b1, 1'b0, 2'd0}},
      '{ROW_UPDATE, '0, 32'd5,    1'b1, 4'b0000, 1'b1, '{1'b1, 1'b0, 1'b0, 2'd0}},
      '{ROW_UPDATE, '0, 32'hFFFF_FFFE, 1'b0, 4'b0100, 1'b0, '0},
      '{ROW_UPDATE, '0, MS_MAX,   1'b1, 4'b0110, 1'b0, '0},
      '{ROW_UPDATE, '0, 32'd3,    1'b0, 4'b0000, 1'b0, '0},
      '{ROW_UPDATE, '0, 32'd4,    1'b1, 4'b0000, 1'b0, '0}
    };

    // Reset held from the start, released on a falling edge
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        drain_updates();
        write_reg(directed_rows[r].idx, directed_rows[r].value);
        settings_used++;
      end else begin
        send_update(directed_rows[r].value, directed_rows[r].focus, directed_rows[r].req,
                    directed_rows[r].known, directed_rows[r].want);
      end
    end

    // Random phases, each with fresh register settings and traffic shape
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_updates();
      if (phase == 0) begin
        len = '0;
        act = 32'd7;
      end else if (phase == 1) begin
        len = MS_MAX;
        act = 32'd4;
      end else begin
        len = pick_span();
        act = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 32'd4;
      end
      write_reg(cgsp_pkg::REG_PULSE_LENGTH, len);
      write_reg(cgsp_pkg::REG_ACTIVE_SRCS, act);
      cd = (phase == 0) ? '0 : (phase == 1) ? MS_MAX : pick_span();
      write_reg(cgsp_pkg::REG_COOLDOWN0, cd);
      cd = (phase == 0) ? '0 : (phase == 1) ? MS_MAX : pick_span();
      write_reg(cgsp_pkg::REG_COOLDOWN1, cd);
      cd = (phase == 0) ? '0 : (phase == 1) ? MS_MAX : pick_span();
      write_reg(cgsp_pkg::REG_COOLDOWN2, cd);
      cd = (phase == 0) ? '0 : (phase == 1) ? MS_MAX : pick_span();
      write_reg(cgsp_pkg::REG_COOLDOWN3, cd);
      settings_used++;

      sender_idle   = (phase % 3) != 0;
      receiver_idle = (phase % 4) != 1;
      // back-to-back sender against a long receiver hold-off
      if (phase == 4) begin
        sender_idle  = 1'b0;
        hold_off_req = 1'b1;
      end

      clock = (phase % 2) ? MS_MAX - $urandom_range(0, 400) : $urandom;
      for (int k = 0; k < PHASE_UPDATES; k++) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) clock = $urandom;
        else if (roll == 1) clock = clock - $urandom_range(1, 50);
        else clock = clock + $urandom_range(0, 12);
        send_update(clock, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 1'b0, '0);
      end
    end

    // Wind down: all results back, then the summary
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    guard = 0;
    while (awaited_beats.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (awaited_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", awaited_beats.size());
      fault_count++;
    end

    $display("Run covered %0d updates, %0d pulses started, %0d register settings.",
             updates_sent, pulses_seen, settings_used);
    $display("Included wrapping timestamps, a long receiver hold-off and idle/dense traffic.");
    if (fault_count == 0) begin
      $display("PASS cooldown_gated_shutter_pulser_core");
    end else begin
      $display("FAIL cooldown_gated_shutter_pulser_core");
    end
    $finish;
  end

endmodule
